@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is held
`define MAOS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion that also holds during reset
`define MAOS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ design/maos_pkg.sv @@
// ---------------------------------------------------------------------------
// maos_pkg
// shared types and constants of the auto-off switch bank
// ---------------------------------------------------------------------------
package maos_pkg;

    // field widths
    localparam int OP_W  = 2;
    localparam int CH_W  = 4;
    localparam int VAL_W = 16;
    localparam int MAP_W = 16;

    // reports per input item at most, and the width of their counter
    localparam int MAX_REPORTS = 16;
    localparam int RPT_CNT_W   = 5;

    // width used to compare a channel number against the bank size
    localparam int CH_CMP_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_SET    = 2'd0;
    localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the input item, restart counters
        logic exec_cmd;  // apply a set or toggle
        logic rd_issue;  // read the countdown of the current channel
        logic upd;       // update the countdown read last
        logic flush;     // hand the held report to the output as final
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic kind_tick;   // captured item is a tick
        logic upd_stall;   // update must wait for the output register
        logic last_ch;     // sweep is on the last channel
        logic flush_done;  // held report is gone or leaves this cycle
    } t_dp_sts;

endpackage

@@ design/maos_ram.sv @@
// ---------------------------------------------------------------------------
// maos_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module maos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/maos_ctrl.sv @@
// ---------------------------------------------------------------------------
// maos_ctrl
// sequencer: takes one item, runs a command or a tick sweep, drains report
// ---------------------------------------------------------------------------
module maos_ctrl import maos_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_RD,
        S_UPD,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = i_sts.kind_tick ? S_RD : S_FLUSH;
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!i_sts.upd_stall) begin
                    n_state = i_sts.last_ch ? S_FLUSH : S_RD;
                end
            end
            S_FLUSH: begin
                if (i_sts.flush_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.latch    = (r_state == S_IDLE) && i_valid;
        o_cmd.exec_cmd = (r_state == S_DISP);
        o_cmd.rd_issue = (r_state == S_RD);
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.flush    = (r_state == S_FLUSH);
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ design/maos_dp.sv @@
// ---------------------------------------------------------------------------
// maos_dp
// levels, countdown memory, report holding slot and output register
// ---------------------------------------------------------------------------
module maos_dp import maos_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic [OP_W-1:0]  i_op,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [CH_W-1:0]  o_changed_channel,
    output logic             o_new_level,
    output logic [MAP_W-1:0] o_all_levels,
    output logic             o_last
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // captured item
    logic [OP_W-1:0]  r_op;
    logic [CH_W-1:0]  r_ch;
    logic [VAL_W-1:0] r_val;

    // channel state
    logic [CHANNELS-1:0] r_lv;
    logic [CHANNELS-1:0] r_cd_vld;

    // sweep control
    logic [IW-1:0]        r_idx;
    logic [RPT_CNT_W-1:0] r_cnt;

    // report holding slot
    logic             r_pend_vld;
    logic [CH_W-1:0]  r_pend_ch;
    logic             r_pend_lvl;
    logic [MAP_W-1:0] r_pend_map;

    // output register
    logic             r_o_valid;
    logic [CH_W-1:0]  r_o_ch;
    logic             r_o_lvl;
    logic [MAP_W-1:0] r_o_map;
    logic             r_o_last;

    logic [IW-1:0]       ch_idx;
    logic                ch_ok;
    logic                kind_cmd;
    logic                cmd_lvl;
    logic [VAL_W-1:0]    cmd_cd;
    logic [VAL_W-1:0]    ram_rdata;
    logic [VAL_W-1:0]    cur_cd;
    logic                running;
    logic                expire;
    logic                rep;
    logic                out_free;
    logic                stall;
    logic                upd_go;
    logic                cmd_go;
    logic                new_rep;
    logic                flush_load;
    logic [CHANNELS-1:0] lv_next;
    logic [MAP_W-1:0]    map_next;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;

    // command decode on the captured item
    always_comb begin
        ch_idx   = IW'(r_ch);
        ch_ok    = {{(CH_CMP_W-CH_W){1'b0}}, r_ch} < CH_CMP_W'(CHANNELS);
        kind_cmd = ch_ok && ((r_op == OP_SET) || (r_op == OP_TOGGLE));
        cmd_lvl  = (r_op == OP_SET) ? (r_val != '0) : !r_lv[ch_idx];
        cmd_cd   = ((r_op == OP_SET) && (r_val > VAL_W'(1))) ? r_val : '0;
    end

    // countdown step of the swept channel
    always_comb begin
        cur_cd  = r_cd_vld[r_idx] ? ram_rdata : '0;
        running = (cur_cd != '0);
        expire  = (cur_cd == VAL_W'(1));
    end

    // report and handshake control
    always_comb begin
        rep        = i_cmd.upd && expire && (r_cnt < RPT_CNT_W'(MAX_REPORTS));
        out_free   = !r_o_valid || i_ready;
        stall      = rep && r_pend_vld && !out_free;
        upd_go     = i_cmd.upd && !stall;
        cmd_go     = i_cmd.exec_cmd && kind_cmd;
        new_rep    = cmd_go || (upd_go && rep);
        flush_load = i_cmd.flush && r_pend_vld && out_free;
    end

    // levels after this cycle's write
    always_comb begin
        lv_next = r_lv;
        if (cmd_go) begin
            lv_next[ch_idx] = cmd_lvl;
        end
        if (upd_go && expire) begin
            lv_next[r_idx] = 1'b0;
        end
    end

    // visible bitmap, channels above the map width are not shown
    for (genvar g = 0; g < MAP_W; g++) begin : g_map
        if (g < CHANNELS) begin : g_on
            assign map_next[g] = lv_next[g];
        end else begin : g_off
            assign map_next[g] = 1'b0;
        end
    end

    // countdown memory write
    always_comb begin
        ram_we    = cmd_go || (upd_go && running);
        ram_waddr = cmd_go ? ch_idx : r_idx;
        ram_wdata = cmd_go ? cmd_cd : cur_cd - VAL_W'(1);
    end

    maos_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CHANNELS),
        .AW    (IW)
    ) u_cd_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_op;
            r_ch  <= i_channel;
            r_val <= i_value;
        end
    end

    // channel state, countdown valid bits, sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv     <= '0;
            r_cd_vld <= '0;
            r_idx    <= '0;
            r_cnt    <= '0;
        end else begin
            r_lv <= lv_next;
            if (ram_we) begin
                r_cd_vld[ram_waddr] <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_idx <= '0;
                r_cnt <= '0;
            end else begin
                if (upd_go) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (new_rep) begin
                    r_cnt <= r_cnt + RPT_CNT_W'(1);
                end
            end
        end
    end

    // holding slot, keeps one report until it is known whether it is final
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (new_rep) begin
            r_pend_vld <= 1'b1;
        end else if (flush_load) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (new_rep) begin
            r_pend_ch  <= cmd_go ? r_ch : CH_W'(r_idx);
            r_pend_lvl <= cmd_go ? cmd_lvl : 1'b0;
            r_pend_map <= map_next;
        end
    end

    // output register, a newer report pushes the held one out as not final
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((new_rep && r_pend_vld) || flush_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((new_rep && r_pend_vld) || flush_load) begin
            r_o_ch   <= r_pend_ch;
            r_o_lvl  <= r_pend_lvl;
            r_o_map  <= r_pend_map;
            r_o_last <= flush_load;
        end
    end

    // status to the sequencer
    always_comb begin
        o_sts            = '0;
        o_sts.kind_tick  = (r_op == OP_TICK);
        o_sts.upd_stall  = stall;
        o_sts.last_ch    = (r_idx == IW'(CHANNELS - 1));
        o_sts.flush_done = !r_pend_vld || out_free;
    end

    assign o_valid           = r_o_valid;
    assign o_changed_channel = r_o_ch;
    assign o_new_level       = r_o_lvl;
    assign o_all_levels      = r_o_map;
    assign o_last            = r_o_last;

endmodule

@@ design/multi_channel_auto_off_switch_top.sv @@
// ---------------------------------------------------------------------------
// multi_channel_auto_off_switch_top
// bank of on/off channels with per-channel auto-off countdown
// ---------------------------------------------------------------------------
// One item is taken at a time. A set or toggle is captured, then applied with
// its report put in the holding slot, then flushed to the output register; a
// tick sweeps the countdown memory one channel at a time (read, then update
// through its single read port), and an update waits while the output side
// holds back a report. Reports leave through a one-deep holding slot
// and the output register, so the final report is flagged without lookahead
// and the next item is taken while that report still waits. At most 16
// reports go out per tick; further expiring channels still switch off.
// ---------------------------------------------------------------------------
module multi_channel_auto_off_switch_top import maos_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [OP_W-1:0]  i_op,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CH_W-1:0]  o_changed_channel,
    output logic             o_new_level,
    output logic [MAP_W-1:0] o_all_levels,
    output logic             o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    maos_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // datapath
    maos_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts),
        .i_op              (i_op),
        .i_channel         (i_channel),
        .i_value           (i_value),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_changed_channel (o_changed_channel),
        .o_new_level       (o_new_level),
        .o_all_levels      (o_all_levels),
        .o_last            (o_last)
    );

endmodule

@@ design/maos_checker.sv @@
// ---------------------------------------------------------------------------
// maos_checker
// port level checks of the switch bank, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module maos_checker import maos_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [CH_W-1:0]  o_changed_channel,
    input logic             o_new_level,
    input logic [MAP_W-1:0] o_all_levels,
    input logic             o_last
);

    // stalled report holds
    `MAOS_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_changed_channel)
        && $stable(o_new_level) && $stable(o_all_levels) && $stable(o_last))

    // no report straight after reset
    `MAOS_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid)

    // one item at a time: input closes after a transfer
    `MAOS_ASSERT(a_one_item, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready)

    // a channel switched on shows in the bitmap
    `MAOS_ASSERT(a_on_in_map, i_clk, i_rst_n, o_valid && o_new_level |-> o_all_levels[o_changed_channel])

endmodule

bind multi_channel_auto_off_switch_top maos_checker u_maos_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_changed_channel (o_changed_channel),
    .o_new_level       (o_new_level),
    .o_all_levels      (o_all_levels),
    .o_last            (o_last)
);
